// ----- sv/drs_pkg.sv -----
// Package with the widths, types and state codes shared by the decimal radix sorter files.
`default_nettype none

package drs_pkg;

  // Capacity of one batch, in items.
  localparam int unsigned MaxItems = 64;

  // Field widths of one transaction.
  localparam int unsigned KeyW = 31;
  localparam int unsigned TagW = 32;

  // Width of the item counter, which must hold MaxItems itself.
  localparam int unsigned CntW = $clog2(MaxItems + 1);

  // One stored key and tag pair as it sits in a cell.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic            insert;
    logic            shift;
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    StLoad = 2'b01,
    StEmit = 2'b10
  } state_e;

endpackage

`default_nettype wire

// ----- sv/drs_ifs.sv -----
// Valid and ready channel interfaces for the input and result transactions of the sorter.
`default_nettype none

interface drs_in_if;
  logic                      valid;
  logic                      ready;
  logic [drs_pkg::KeyW-1:0]  sort_key;
  logic [drs_pkg::TagW-1:0]  payload_tag;
  logic                      batch_end;

  modport source (output valid, output sort_key, output payload_tag, output batch_end,
                  input ready);
  modport sink (input valid, input sort_key, input payload_tag, input batch_end,
                output ready);
endinterface

interface drs_out_if;
  logic                      valid;
  logic                      ready;
  logic [drs_pkg::KeyW-1:0]  sorted_key;
  logic [drs_pkg::TagW-1:0]  sorted_tag;
  logic                      run_end;
  logic                      overflowed;

  modport source (output valid, output sorted_key, output sorted_tag, output run_end,
                  output overflowed, input ready);
  modport sink (input valid, input sorted_key, input sorted_tag, input run_end,
                input overflowed, output ready);
endinterface

`default_nettype wire

// ----- sv/decimal_radix_sorter.sv -----
// Top level of the batch sorter: load sequencer, chain of sorting cells and result port.
`default_nettype none

// The sorter collects a batch of key and tag pairs and returns them in ascending key
// order, with equal keys kept in arrival order, exactly as a stable base-ten
// least-significant-digit radix sort orders them. The order is built while the batch
// loads: a row of MaxItems identical cells holds the batch sorted at all times, and each
// accepted transaction is broadcast to every cell, which compares it with its own key
// and either keeps its entry, takes the new pair, or takes the entry of its left
// neighbor so that the row opens a slot at the right place. While loading, the input is
// ready for every transaction. The transaction with batch_end set closes the batch; from
// the next cycle the results stream out of the first cell, one per cycle while the sink
// is ready, and every result hands the row one place to the left. There is no sort time
// between the last input and the first result; the input is not ready while results
// are being delivered, and it is ready again in the cycle after the result marked
// run_end is taken. Once MaxItems items are stored, further items of the batch are
// dropped, and every result of that batch shows overflowed. An item with batch_end set
// still closes the batch when it is dropped.

module decimal_radix_sorter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  drs_in_if.sink    in_i,
  drs_out_if.source out_o
);

  drs_pkg::state_e          state_q, state_d;
  logic [drs_pkg::CntW-1:0] count_q, count_d;
  logic                     ovf_q, ovf_d;

  logic                     in_fire;
  logic                     out_fire;
  logic                     full;
  logic                     last_out;

  drs_pkg::cell_ctrl_t      ctrl;
  drs_pkg::entry_t          cell_entry [drs_pkg::MaxItems];
  logic                     cell_ins   [drs_pkg::MaxItems];

  // Handshakes. Input is taken only while loading; results are shown only while
  // emitting, straight from the registers of the first cell.
  assign in_i.ready = (state_q == drs_pkg::StLoad);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  assign full     = (count_q == drs_pkg::CntW'(drs_pkg::MaxItems));
  assign last_out = (count_q == drs_pkg::CntW'(1));

  // Broadcast control for the row. A transaction that finds the row full is dropped.
  always_comb begin
    ctrl.insert = in_fire && !full;
    ctrl.shift  = out_fire;
    ctrl.key    = in_i.sort_key;
    ctrl.tag    = in_i.payload_tag;
  end

  // The row of cells. Cell zero always holds the smallest key. Its left side is tied to
  // a valid entry that never moves, so that an empty row puts the first item in cell zero.
  for (genvar i = 0; i < drs_pkg::MaxItems; i++) begin : g_cell
    drs_pkg::entry_t left_entry;
    drs_pkg::entry_t right_entry;
    logic            left_ins;

    if (i == 0) begin : g_first
      assign left_entry = '{valid: 1'b1, key: '0, tag: '0};
      assign left_ins   = 1'b0;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_ins   = cell_ins[i-1];
    end

    if (i == drs_pkg::MaxItems - 1) begin : g_last
      assign right_entry = '{valid: 1'b0, key: '0, tag: '0};
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    drs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .left_i     (left_entry),
      .left_ins_i (left_ins),
      .right_i    (right_entry),
      .entry_o    (cell_entry[i]),
      .ins_o      (cell_ins[i])
    );
  end

  // Sequencer. The count tracks stored items while loading and remaining results while
  // emitting; the result that brings it to zero carries run_end and reopens the input.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      drs_pkg::StLoad: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + drs_pkg::CntW'(1);
          end
          if (in_i.batch_end) begin
            state_d = drs_pkg::StEmit;
          end
        end
      end
      drs_pkg::StEmit: begin
        if (out_fire) begin
          count_d = count_q - drs_pkg::CntW'(1);
          if (last_out) begin
            state_d = drs_pkg::StLoad;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = drs_pkg::StLoad;
        count_d = '0;
        ovf_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drs_pkg::StLoad;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Result transaction.
  assign out_o.valid      = (state_q == drs_pkg::StEmit);
  assign out_o.sorted_key = cell_entry[0].key;
  assign out_o.sorted_tag = cell_entry[0].tag;
  assign out_o.run_end    = last_out;
  assign out_o.overflowed = ovf_q;

endmodule

`default_nettype wire

// ----- sv/drs_cell.sv -----
// One cell of the sorting chain: holds one entry, inserts or shifts with its neighbors.
`default_nettype none

module drs_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire drs_pkg::cell_ctrl_t ctrl_i,
  input  wire drs_pkg::entry_t     left_i,
  input  wire logic                left_ins_i,
  input  wire drs_pkg::entry_t     right_i,
  output drs_pkg::entry_t          entry_o,
  output logic                     ins_o
);

  logic                     valid_q, valid_d;
  logic [drs_pkg::KeyW-1:0] key_q, key_d;
  logic [drs_pkg::TagW-1:0] tag_q, tag_d;
  logic                     ins;

  // The new key belongs in front of this entry only when strictly smaller,
  // so equal keys stay in arrival order.
  assign ins = valid_q && (key_q > ctrl_i.key);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    if (ctrl_i.shift) begin
      valid_d = right_i.valid;
      key_d   = right_i.key;
      tag_d   = right_i.tag;
    end else if (ctrl_i.insert) begin
      // A displaced left neighbor pushes its entry into this cell, whether this
      // cell is occupied or is the first free slot.
      if (left_ins_i) begin
        valid_d = left_i.valid;
        key_d   = left_i.key;
        tag_d   = left_i.tag;
      end else if (ins || (!valid_q && left_i.valid)) begin
        valid_d = 1'b1;
        key_d   = ctrl_i.key;
        tag_d   = ctrl_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, tag: tag_q};
  assign ins_o   = ins;

endmodule

`default_nettype wire

// ----- sim/decimal_radix_sorter_tb.sv -----
// Self-checking testbench for the decimal radix sorter: random batches, radix-sort predictor.
`timescale 1ns / 1ps

// The testbench streams batches of key and tag pairs into the sorter and checks every
// sorted result against its own predictor. The predictor keeps a copy of the batch as it
// loads. On the transaction that closes the batch, it runs a stable base-ten
// least-significant-digit radix sort over the stored pairs and queues the results it
// expects. The monitor takes each result transaction and compares it field by field with
// the oldest queued expectation.
//
// The run has three traffic phases. In the first, the sender idles 35 percent of the time
// and the receiver 49 percent. In the second, the two rates swap. In the third, neither
// side idles. Once in the first phase, the receiver also holds off for a long stretch
// while the sender keeps offering items, so that results back up and the input stalls.
module decimal_radix_sorter_tb;

  localparam int unsigned KeyW        = drs_pkg::KeyW;
  localparam int unsigned TagW        = drs_pkg::TagW;
  localparam int unsigned MaxItems    = drs_pkg::MaxItems;
  localparam int unsigned DigitBase   = 10;
  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned MaxPrinted  = 100;

  // One input transaction as the sender offers it.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
    logic            last;
  } load_item_t;

  // One result transaction as the sorter should deliver it.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
    logic            run_end;
    logic            overflowed;
  } sorted_rec_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  drs_in_if  in_if ();
  drs_out_if out_if ();

  decimal_radix_sorter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Everything the testbench drives is held in local registers. These have known values
  // from time zero and reach the interfaces through continuous assignments.
  logic            drv_valid = 1'b0;
  logic [KeyW-1:0] drv_key   = '0;
  logic [TagW-1:0] drv_tag   = '0;
  logic            drv_last  = 1'b0;
  logic            rcv_ready = 1'b0;

  assign in_if.valid       = drv_valid;
  assign in_if.sort_key    = drv_key;
  assign in_if.payload_tag = drv_tag;
  assign in_if.batch_end   = drv_last;
  assign out_if.ready      = rcv_ready;

  // Items waiting to be offered, and results the sorter still owes.
  load_item_t  pending_q[$];
  sorted_rec_t sorted_q[$];
  load_item_t  cur_item;

  int unsigned total_items = 0;
  int unsigned taken_cnt   = 0;
  int unsigned err_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;

  // Predictor copy of the batch that is loading.
  logic [KeyW-1:0] batch_key[MaxItems];
  logic [TagW-1:0] batch_tag[MaxItems];
  int unsigned     batch_cnt  = 0;
  logic            batch_drop = 1'b0;

  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Reset is asserted once, from time zero, and released at a rising edge.
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // The traffic phase follows the share of the items taken so far. The counter is
  // updated with nonblocking assignments, so every process reads the same value at an edge.
  function automatic int unsigned traffic_phase();
    if (taken_cnt * 3 < total_items) return 0;
    if (taken_cnt * 3 < total_items * 2) return 1;
    return 2;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (traffic_phase())
      0: return 35;
      1: return 49;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct();
    case (traffic_phase())
      0: return 49;
      1: return 35;
      default: return 0;
    endcase
  endfunction

  // Decimal digit of a key at the given weight.
  function automatic int unsigned digit_of(logic [KeyW-1:0] key, longint unsigned weight);
    return int'((64'(key) / weight) % DigitBase);
  endfunction

  // Sorts the loaded batch with one counting pass per decimal digit of the largest key.
  // Each pass scatters from the back to the front, which keeps equal keys in arrival
  // order. The sorted pairs are then queued as the results the sorter owes.
  task automatic close_batch();
    logic [KeyW-1:0] tmp_key[MaxItems];
    logic [TagW-1:0] tmp_tag[MaxItems];
    int unsigned     bucket[DigitBase];
    longint unsigned weight;
    longint unsigned largest;
    int unsigned     d;
    sorted_rec_t     rec;
    largest = 0;
    for (int i = 0; i < batch_cnt; i++)
      if (64'(batch_key[i]) > largest) largest = 64'(batch_key[i]);
    weight = 1;
    while (largest / weight > 0) begin
      for (int b = 0; b < DigitBase; b++) bucket[b] = 0;
      for (int i = 0; i < batch_cnt; i++) bucket[digit_of(batch_key[i], weight)]++;
      for (int b = 1; b < DigitBase; b++) bucket[b] += bucket[b-1];
      for (int i = batch_cnt; i > 0; i--) begin
        d = digit_of(batch_key[i-1], weight);
        bucket[d]--;
        tmp_key[bucket[d]] = batch_key[i-1];
        tmp_tag[bucket[d]] = batch_tag[i-1];
      end
      for (int i = 0; i < batch_cnt; i++) begin
        batch_key[i] = tmp_key[i];
        batch_tag[i] = tmp_tag[i];
      end
      weight *= DigitBase;
    end
    for (int i = 0; i < batch_cnt; i++) begin
      rec.key        = batch_key[i];
      rec.tag        = batch_tag[i];
      rec.run_end    = (i + 1 == batch_cnt);
      rec.overflowed = batch_drop;
      sorted_q.push_back(rec);
    end
    batch_cnt  = 0;
    batch_drop = 1'b0;
  endtask

  // Predicts the effect of one accepted input transaction. Once the batch is full, the
  // item is dropped and the batch is marked, even when the item closes the batch.
  task automatic load_item(load_item_t item);
    if (batch_cnt < MaxItems) begin
      batch_key[batch_cnt] = item.key;
      batch_tag[batch_cnt] = item.tag;
      batch_cnt++;
    end else begin
      batch_drop = 1'b1;
    end
    if (item.last) close_batch();
  endtask

  task automatic flag_mismatch(string msg);
    if (err_cnt < MaxPrinted) $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Draws keys of several shapes. Small ranges give many equal keys, so that stability
  // is tested. Powers of ten and their neighbors sit where one more digit pass begins.
  // Random widths up to the full key move every bit.
  function automatic logic [KeyW-1:0] gen_key();
    longint unsigned p;
    int unsigned     w;
    case ($urandom_range(9))
      0, 1, 2: return KeyW'($urandom_range(20));
      3: begin
        p = 1;
        repeat ($urandom_range(9)) p *= DigitBase;
        if ($urandom_range(1) == 1) p = p - 1;
        return p[KeyW-1:0];
      end
      4: return {KeyW{1'b1}} - KeyW'($urandom_range(3));
      default: begin
        w = $urandom_range(KeyW, 1);
        return KeyW'($urandom & ((64'd1 << w) - 1));
      end
    endcase
  endfunction

  task automatic add_item(logic [KeyW-1:0] key, logic [TagW-1:0] tag, logic last);
    load_item_t item;
    item.key  = key;
    item.tag  = tag;
    item.last = last;
    pending_q.push_back(item);
  endtask

  task automatic add_batch(int unsigned size);
    for (int i = 0; i < size; i++) add_item(gen_key(), $urandom, i + 1 == size);
  endtask

  // Driver. The offered item stays on the channel until it is taken. After that, the
  // next item follows at once or after the sender idles, as the traffic phase decides.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        load_item(cur_item);
        taken_cnt <= taken_cnt + 1;
      end
      if (!drv_valid || in_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          cur_item = pending_q.pop_front();
          drv_valid <= 1'b1;
          drv_key   <= cur_item.key;
          drv_tag   <= cur_item.tag;
          drv_last  <= cur_item.last;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off. It starts once, a quarter of the way through the items, and
  // its length is counted here in cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && taken_cnt * 4 >= total_items) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor. It takes each result transaction, checks it against the oldest expectation,
  // and then chooses the receiver's readiness for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    sorted_rec_t want;
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_if.valid && rcv_ready) begin
        if (sorted_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result key=%0d tag=%0h",
                                  out_if.sorted_key, out_if.sorted_tag));
        end else begin
          want = sorted_q.pop_front();
          if (out_if.sorted_key !== want.key || out_if.sorted_tag !== want.tag ||
              out_if.run_end !== want.run_end || out_if.overflowed !== want.overflowed)
            flag_mismatch($sformatf(
              "key %0d/%0d tag %0h/%0h run_end %b/%b overflowed %b/%b (got/expected)",
              out_if.sorted_key, want.key, out_if.sorted_tag, want.tag,
              out_if.run_end, want.run_end, out_if.overflowed, want.overflowed));
        end
      end
      rcv_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // Watchdog for a sorter that hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned rand_cnt;
    int unsigned batch_idx;
    int unsigned size;
    // Directed batches. A single item with the smallest key and tag, then one with the
    // largest. Next come equal keys whose tags must keep arrival order, then keys that
    // span one, two, three, nine and ten digits, and finally a batch of identical keys.
    add_item('0, '0, 1'b1);
    add_item({KeyW{1'b1}}, {TagW{1'b1}}, 1'b1);
    add_item(KeyW'(7), TagW'(1), 1'b0);
    add_item(KeyW'(3), TagW'(2), 1'b0);
    add_item(KeyW'(7), TagW'(3), 1'b0);
    add_item(KeyW'(3), TagW'(4), 1'b0);
    add_item(KeyW'(7), TagW'(5), 1'b1);
    add_item({KeyW{1'b1}}, $urandom, 1'b0);
    add_item(KeyW'(1000000000), $urandom, 1'b0);
    add_item(KeyW'(999999999), $urandom, 1'b0);
    add_item(KeyW'(10), $urandom, 1'b0);
    add_item(KeyW'(9), $urandom, 1'b0);
    add_item(KeyW'(0), $urandom, 1'b0);
    add_item(KeyW'(100), $urandom, 1'b1);
    add_item(KeyW'(0), 32'hAAAA_5555, 1'b0);
    add_item(KeyW'(0), 32'h5555_AAAA, 1'b1);

    // Random batches, mostly short. One batch fills the store exactly. One overflows it,
    // so the item that closes it is dropped. A few more large batches are mixed in.
    rand_cnt  = 0;
    batch_idx = 0;
    while (rand_cnt < RandomItems) begin
      if (batch_idx == 2) size = MaxItems;
      else if (batch_idx == 5) size = MaxItems + 3;
      else if ($urandom_range(99) < 6) size = $urandom_range(MaxItems + 6, MaxItems - 4);
      else size = $urandom_range(12, 1);
      add_batch(size);
      rand_cnt += size;
      batch_idx++;
    end
    total_items = pending_q.size();

    while (taken_cnt != total_items) @(posedge clk_i);
    while (sorted_q.size() != 0) @(posedge clk_i);
    // Any stray result after the last expected one is still caught by the monitor.
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
